// File: rtl/core/itp_pkg.sv
// ---------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and character helpers for the infix to postfix
// converter: operator codes, precedence, symbol classes and the command and
// status structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
package itp_pkg;

    // Default operator stack depth and the fixed width of the stack pointer
    localparam int STACK_DEPTH_DEF = 32;
    localparam int TOP_W           = 6;

    // Characters of interest
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
    localparam logic [7:0] CH_DOL   = 8'h24;  // '$'
    localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
    localparam logic [7:0] CH_ADD   = 8'h2B;  // '+'
    localparam logic [7:0] CH_SUB   = 8'h2D;  // '-'
    localparam logic [7:0] CH_NUL   = 8'h00;  // expression terminator

    // Stack entry codes
    typedef logic [2:0] t_code;
    localparam t_code CODE_NONE = 3'd0;
    localparam t_code CODE_OPEN = 3'd1;
    localparam t_code CODE_POW  = 3'd2;
    localparam t_code CODE_DOL  = 3'd3;
    localparam t_code CODE_MUL  = 3'd4;
    localparam t_code CODE_DIV  = 3'd5;
    localparam t_code CODE_ADD  = 3'd6;
    localparam t_code CODE_SUB  = 3'd7;

    // Error codes carried by a result
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_CLOSE    = 2'd2,
        ERR_OPEN     = 2'd3
    } t_err;

    // Class of the item being worked on
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_END,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_ALNUM,
        CLS_OP
    } t_cls;

    // Source of a word loaded into the output register
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_PEND,
        OUT_MARK
    } t_out_sel;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic     latch;      // capture input transaction
        logic     push;       // push the item's code
        logic     pop;        // drop top of stack
        logic     pend_load;  // top operator into pending slot
        logic     pend_clear; // pending slot emptied
        t_out_sel out_sel;
        logic     out_last;
        logic     mark_sym;   // mark carries the symbol, else NUL
        t_err     mark_err;
        logic     set_err3;   // unmatched '(' seen while draining
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cls cls;
        logic empty;
        logic full;
        logic top_open;
        logic prec_ge;
        logic pend_valid;
        logic out_free;
        logic err3;
    } t_stat;

    // Operator code of a character, CODE_NONE if not an operator
    function automatic t_code f_op_code(input logic [7:0] c);
        t_code r;
        case (c)
            CH_POW:  r = CODE_POW;
            CH_DOL:  r = CODE_DOL;
            CH_MUL:  r = CODE_MUL;
            CH_DIV:  r = CODE_DIV;
            CH_ADD:  r = CODE_ADD;
            CH_SUB:  r = CODE_SUB;
            default: r = CODE_NONE;
        endcase
        return r;
    endfunction

    // Character emitted for a stacked code
    function automatic logic [7:0] f_code_char(input t_code code);
        logic [7:0] r;
        case (code)
            CODE_OPEN: r = CH_OPEN;
            CODE_POW:  r = CH_POW;
            CODE_DOL:  r = CH_DOL;
            CODE_MUL:  r = CH_MUL;
            CODE_DIV:  r = CH_DIV;
            CODE_ADD:  r = CH_ADD;
            CODE_SUB:  r = CH_SUB;
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

    // Precedence: '^' '$' 3, '*' '/' 2, '+' '-' 1, '(' 0
    function automatic logic [1:0] f_code_prec(input t_code code);
        logic [1:0] r;
        case (code)
            CODE_POW, CODE_DOL: r = 2'd3;
            CODE_MUL, CODE_DIV: r = 2'd2;
            CODE_ADD, CODE_SUB: r = 2'd1;
            default:            r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

// File: rtl/core/infix_to_postfix_converter_unit.sv
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix converter, one ASCII character per
// transaction, with an operator stack of STACK_DEPTH entries.
// ---------------------------------------------------------------------------
// One input transaction is handled at a time. A character is first captured
// in the input holding register and then acted on; every operator popped off
// the stack, and every unmatched '(' dropped at the end of an expression, adds
// a step of its own, since the stack memory has a single registered read port
// and yields one top entry per cycle, and a closing mark (terminator or error
// word) that follows popped operators is sent after the last of them.
// Ignored characters and pushes free the input once they are acted on.
// Results leave through an output register, so a stalled consumer holds the
// block only when a further result is due. The stack memory needs no clearing
// after reset; of the stack, only the pointer is reset.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_expr,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last,
    output logic [1:0] o_error
);

    itp_pkg::t_cmd  cmd;
    itp_pkg::t_stat stat;

    // Controller
    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath
    itp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_symbol      (i_symbol),
        .i_end_of_expr (i_end_of_expr),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_last        (o_last),
        .o_error       (o_error),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

// File: rtl/core/itp_ctrl.sv
// ---------------------------------------------------------------------------
// itp_ctrl
// Controller: accepts one input transaction at a time and steps the
// datapath through pops, pushes and result emission for it.
// ---------------------------------------------------------------------------
module itp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  itp_pkg::t_stat i_stat,
    output itp_pkg::t_cmd  o_cmd
);

    itp_pkg::t_state r_state, n_state;

    // Requested actions for the current item
    logic          go_pop;   // pop one operator and emit it
    logic          go_mark;  // emit a final mark word
    logic          go_fin;   // finish, last word is the pending one
    logic          fin_push;
    logic          fin_pop;
    logic          mark_sym;
    itp_pkg::t_err mark_err;
    logic          fin_ok;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide what the current item needs this cycle
    always_comb begin
        go_pop   = 1'b0;
        go_mark  = 1'b0;
        go_fin   = 1'b0;
        fin_push = 1'b0;
        fin_pop  = 1'b0;
        mark_sym = 1'b0;
        mark_err = itp_pkg::ERR_NONE;
        unique case (i_stat.cls)
            itp_pkg::CLS_END: begin
                if (i_stat.empty) begin
                    go_mark  = 1'b1;
                    mark_err = i_stat.err3 ? itp_pkg::ERR_OPEN : itp_pkg::ERR_NONE;
                end else if (!i_stat.top_open) begin
                    go_pop = 1'b1;
                end
            end
            itp_pkg::CLS_OPEN: begin
                if (i_stat.full) begin
                    go_mark  = 1'b1;
                    mark_err = itp_pkg::ERR_OVERFLOW;
                end else begin
                    go_fin   = 1'b1;
                    fin_push = 1'b1;
                end
            end
            itp_pkg::CLS_ALNUM: begin
                go_mark  = 1'b1;
                mark_sym = 1'b1;
            end
            itp_pkg::CLS_OP: begin
                if (!i_stat.empty && !i_stat.top_open && i_stat.prec_ge) begin
                    go_pop = 1'b1;
                end else if (!i_stat.full) begin
                    go_fin   = 1'b1;
                    fin_push = 1'b1;
                end else begin
                    go_mark  = 1'b1;
                    mark_err = itp_pkg::ERR_OVERFLOW;
                end
            end
            itp_pkg::CLS_CLOSE: begin
                if (i_stat.empty) begin
                    go_mark  = 1'b1;
                    mark_err = itp_pkg::ERR_CLOSE;
                end else if (i_stat.top_open) begin
                    go_fin  = 1'b1;
                    fin_pop = 1'b1;
                end else begin
                    go_pop = 1'b1;
                end
            end
            default: begin
                go_fin = 1'b1;
            end
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        fin_ok  = !i_stat.pend_valid || i_stat.out_free;
        unique case (r_state)
            itp_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = itp_pkg::ST_RUN;
                end
            end
            itp_pkg::ST_RUN: begin
                // '(' found while draining: drop it and remember
                if (i_stat.cls == itp_pkg::CLS_END && !i_stat.empty && i_stat.top_open) begin
                    o_cmd.pop      = 1'b1;
                    o_cmd.set_err3 = 1'b1;
                end
                // Pop an operator; the previous one leaves, not last
                if (go_pop && fin_ok) begin
                    o_cmd.pop       = 1'b1;
                    o_cmd.pend_load = 1'b1;
                    if (i_stat.pend_valid) begin
                        o_cmd.out_sel = itp_pkg::OUT_PEND;
                    end
                end
                // Final mark; a pending operator goes out first
                if (go_mark && i_stat.out_free) begin
                    if (i_stat.pend_valid) begin
                        o_cmd.out_sel    = itp_pkg::OUT_PEND;
                        o_cmd.pend_clear = 1'b1;
                    end else begin
                        o_cmd.out_sel  = itp_pkg::OUT_MARK;
                        o_cmd.out_last = 1'b1;
                        o_cmd.mark_sym = mark_sym;
                        o_cmd.mark_err = mark_err;
                        n_state        = itp_pkg::ST_IDLE;
                    end
                end
                // Finish; the pending operator, if any, is the last word
                if (go_fin && fin_ok) begin
                    o_cmd.push = fin_push;
                    o_cmd.pop  = fin_pop;
                    if (i_stat.pend_valid) begin
                        o_cmd.out_sel    = itp_pkg::OUT_PEND;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.pend_clear = 1'b1;
                    end
                    n_state = itp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/itp_dpath.sv
// ---------------------------------------------------------------------------
// itp_dpath
// Datapath: input holding register, operator stack memory with a registered
// top-of-stack read, pending operator slot and the output register.
// ---------------------------------------------------------------------------
module itp_dpath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_symbol,
    input  logic           i_end_of_expr,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [7:0]     o_out_char,
    output logic           o_last,
    output logic [1:0]     o_error,
    input  itp_pkg::t_cmd  i_cmd,
    output itp_pkg::t_stat o_stat
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Held input transaction
    logic [7:0] r_sym;
    logic       r_end;

    // Stack storage and pointer
    itp_pkg::t_code               r_stack [STACK_DEPTH];
    itp_pkg::t_code               r_tos;
    logic [itp_pkg::TOP_W-1:0]    r_top, n_top, n_top_m1;
    logic [AW-1:0]                wr_addr, rd_addr;
    itp_pkg::t_code               push_code;
    itp_pkg::t_code               item_code;

    // Pending operator and unmatched '(' flag
    logic       r_pend_valid;
    logic [7:0] r_pend_char;
    logic       r_err3;

    // Output register
    logic          r_o_valid;
    logic [7:0]    r_o_char;
    logic          r_o_last;
    itp_pkg::t_err r_o_err;
    logic          out_free;

    itp_pkg::t_cls cls;

    // Input holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sym <= i_symbol;
            r_end <= i_end_of_expr;
        end
    end

    // Classify the held item
    assign item_code = itp_pkg::f_op_code(r_sym);
    always_comb begin
        if (r_end) begin
            cls = itp_pkg::CLS_END;
        end else if (r_sym == itp_pkg::CH_OPEN) begin
            cls = itp_pkg::CLS_OPEN;
        end else if (itp_pkg::f_is_alnum(r_sym)) begin
            cls = itp_pkg::CLS_ALNUM;
        end else if (item_code != itp_pkg::CODE_NONE) begin
            cls = itp_pkg::CLS_OP;
        end else if (r_sym == itp_pkg::CH_CLOSE) begin
            cls = itp_pkg::CLS_CLOSE;
        end else begin
            cls = itp_pkg::CLS_OTHER;
        end
    end

    // Stack pointer update and addresses
    always_comb begin
        n_top = r_top;
        if (i_cmd.push) begin
            n_top = r_top + itp_pkg::TOP_W'(1);
        end else if (i_cmd.pop) begin
            n_top = r_top - itp_pkg::TOP_W'(1);
        end
        n_top_m1 = n_top - itp_pkg::TOP_W'(1);
        rd_addr  = (n_top == '0) ? '0 : n_top_m1[AW-1:0];
        wr_addr  = r_top[AW-1:0];
    end

    assign push_code = (cls == itp_pkg::CLS_OPEN) ? itp_pkg::CODE_OPEN : item_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else begin
            r_top <= n_top;
        end
    end

    // Stack memory; read port always tracks the next top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[wr_addr] <= push_code;
            r_tos            <= push_code;
        end else begin
            r_tos <= r_stack[rd_addr];
        end
    end

    // Pending operator slot and error flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_err3       <= 1'b0;
        end else begin
            if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.pend_clear) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.latch) begin
                r_err3 <= 1'b0;
            end else if (i_cmd.set_err3) begin
                r_err3 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_load) begin
            r_pend_char <= itp_pkg::f_code_char(r_tos);
        end
    end

    // Output register
    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_sel != itp_pkg::OUT_NONE) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.out_sel)
            itp_pkg::OUT_PEND: begin
                r_o_char <= r_pend_char;
                r_o_last <= i_cmd.out_last;
                r_o_err  <= itp_pkg::ERR_NONE;
            end
            itp_pkg::OUT_MARK: begin
                r_o_char <= i_cmd.mark_sym ? r_sym : itp_pkg::CH_NUL;
                r_o_last <= i_cmd.out_last;
                r_o_err  <= i_cmd.mark_err;
            end
            default: begin
            end
        endcase
    end

    assign o_valid    = r_o_valid;
    assign o_out_char = r_o_char;
    assign o_last     = r_o_last;
    assign o_error    = r_o_err;

    // Status to the controller
    always_comb begin
        o_stat.cls        = cls;
        o_stat.empty      = (r_top == '0);
        o_stat.full       = (r_top >= itp_pkg::TOP_W'(STACK_DEPTH));
        o_stat.top_open   = (r_tos == itp_pkg::CODE_OPEN);
        o_stat.prec_ge    = (itp_pkg::f_code_prec(r_tos) >= itp_pkg::f_code_prec(item_code));
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
        o_stat.err3       = r_err3;
    end

endmodule

// File: rtl/core/itp_checker.sv
// ---------------------------------------------------------------------------
// itp_checker
// Port-level checks on the converter's input and result streams, bound to the top level.
// ---------------------------------------------------------------------------
module itp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_symbol,
    input logic       i_end_of_expr,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_char,
    input logic       o_last,
    input logic [1:0] o_error
);

    // A waiting input transaction holds its contents
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_symbol) &&
                               $stable(i_end_of_expr))
        else $error("input changed while waiting");

    // A stalled result transaction holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) &&
                               $stable(o_last) && $stable(o_error))
        else $error("result changed while stalled");

    // A NUL character is only ever a closing mark
    a_nul_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_char == 8'h00 |-> o_last)
        else $error("NUL result not marked last");

    // Error words carry NUL
    a_err_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error != 2'd0 |-> o_out_char == 8'h00)
        else $error("error word carries a character");

    // Results before the last of a transaction are plain operators
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_error == 2'd0 && o_out_char != 8'h00)
        else $error("bad intermediate result");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (.*);
